[rtl/pstc_pkg.sv]
// ----------------------------------------------------------------------------
// pstc_pkg: shared types and constants of the parabolic sine/cosine/tangent unit
// Fixed-point constants in Q4.28, request/result item structs, a small helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pstc_pkg;

    localparam int WORK_FRAC           = 28;
    localparam int OUT_FRAC            = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_AW            = 2;

    localparam longint HALF_PI_Q = 64'sd421657428;
    localparam longint PI_Q      = 64'sd843314857;
    localparam longint TWO_PI_Q  = 64'sd1686629713;
    localparam longint B_Q       = 64'sd341782638;
    localparam longint C_Q       = -64'sd108792793;
    localparam longint P_Q       = 64'sd60397978;

    localparam logic [1:0] REQ_SIN = 2'd0;
    localparam logic [1:0] REQ_COS = 2'd1;
    localparam logic [1:0] REQ_TAN = 2'd2;
    localparam logic [1:0] REQ_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic is_nop;
        logic is_tan;
        logic use_cos;
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] angle;
    } t_cmd;

    function automatic logic signed [33:0] abs34(input logic signed [33:0] v);
        abs34 = v[33] ? -v : v;
    endfunction

endpackage

`default_nettype wire

[rtl/pstc_front.sv]
// ----------------------------------------------------------------------------
// pstc_front: request intake
// Registers one request, decodes the selector and pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire pstc_pkg::t_in_item i_data,
    output logic                   o_push,
    input  wire logic              i_q_ready,
    output pstc_pkg::t_cmd         o_cmd
);

    logic           r_valid;
    pstc_pkg::t_cmd r_cmd;
    pstc_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd       = '0;
        n_cmd.angle = i_data.angle;
        unique case (i_data.req_type)
            pstc_pkg::REQ_SIN: begin
            end
            pstc_pkg::REQ_COS: begin
                n_cmd.kind.use_cos = 1'b1;
            end
            pstc_pkg::REQ_TAN: begin
                n_cmd.kind.is_tan = 1'b1;
            end
            default: begin
                n_cmd.kind.is_nop = 1'b1;
            end
        endcase
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/pstc_queue.sv]
// ----------------------------------------------------------------------------
// pstc_queue: command queue
// Small FIFO between the intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pstc_pkg::t_cmd i_data,
    output logic                o_ready,
    output logic                o_valid,
    output pstc_pkg::t_cmd      o_data,
    input  wire logic           i_pop
);

    localparam int AW = pstc_pkg::QUEUE_AW;

    pstc_pkg::t_cmd  r_mem [pstc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [AW:0]     r_count;
    pstc_pkg::t_cmd  r_head;
    logic            r_head_vld;
    logic            w_take;
    logic            w_byp;
    logic            w_wr;
    logic            w_rd;

    assign o_ready = (r_count != (AW+1)'(pstc_pkg::QUEUE_DEPTH));
    assign o_valid = r_head_vld;
    assign o_data  = r_head;
    // head register refills when empty or popped; with the store empty a push
    // goes straight into it
    assign w_take  = !r_head_vld || i_pop;
    assign w_rd    = w_take && (r_count != '0);
    assign w_byp   = w_take && (r_count == '0) && i_push;
    assign w_wr    = i_push && o_ready && !w_byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_head_vld <= 1'b0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
            if (w_take) begin
                r_head_vld <= w_rd || w_byp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (w_rd) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (w_byp) begin
            r_head <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(pstc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

`default_nettype wire

[rtl/pstc_mulq.sv]
// ----------------------------------------------------------------------------
// pstc_mulq: Q4.28 multiplier
// Two-stage sign-magnitude product, rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_mulq (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [33:0] i_a,
    input  wire logic signed [33:0] i_b,
    output logic signed [33:0]      o_p
);

    localparam int FR = pstc_pkg::WORK_FRAC;

    logic signed [33:0] w_aa;
    logic signed [33:0] w_ab;
    logic [32:0]        w_ma;
    logic [32:0]        w_mb;
    logic [65:0]        r_mag;
    logic               r_neg;
    logic [65:0]        w_rnd;
    logic signed [33:0] r_p;

    assign w_aa  = pstc_pkg::abs34(i_a);
    assign w_ab  = pstc_pkg::abs34(i_b);
    assign w_ma  = w_aa[32:0];
    assign w_mb  = w_ab[32:0];
    assign w_rnd = (r_mag + (66'd1 << (FR - 1))) >> FR;
    assign o_p   = r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= 66'(w_ma) * 66'(w_mb);
            r_neg <= i_a[33] ^ i_b[33];
            r_p   <= r_neg ? -signed'(w_rnd[33:0]) : signed'(w_rnd[33:0]);
        end
    end

endmodule

`default_nettype wire

[rtl/pstc_back.sv]
// ----------------------------------------------------------------------------
// pstc_back: arithmetic pipeline
// Two sine lanes (angle and angle + pi/2), then a radix-2 divider for tangent.
// ----------------------------------------------------------------------------
`default_nettype none

module pstc_back #(
    parameter int ANGLE_FRAC_BITS = pstc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire pstc_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output pstc_pkg::t_out_item o_data
);

    localparam int FR   = pstc_pkg::WORK_FRAC;
    localparam int SH   = FR - ANGLE_FRAC_BITS;
    localparam int A_W  = 32 + SH;
    localparam int U_W  = A_W + 1;
    localparam int H_W  = U_W - FR;
    localparam int Q_W  = A_W - 29;
    localparam int QB   = 33;
    localparam int RS   = FR - pstc_pkg::OUT_FRAC;
    localparam int NS   = 17 + QB + 1;

    localparam logic [63:0] TWO_PI_U = 64'(pstc_pkg::TWO_PI_Q);
    localparam logic [63:0] MT       = TWO_PI_U << (A_W - 31);
    localparam logic [63:0] K_SIN    = 64'(pstc_pkg::PI_Q) + MT;
    localparam logic [63:0] K_COS    = K_SIN + 64'(pstc_pkg::HALF_PI_Q);
    localparam logic [63:0] RC       = (64'd1 << 60) / TWO_PI_U;

    typedef struct packed {
        logic        sneg;
        logic        cneg;
        logic        czero;
        logic        ovf;
        logic [31:0] sc;
        logic [32:0] d;
        logic [32:0] rem;
        logic [32:0] nlo;
        logic [32:0] q;
    } t_div;

    logic                  w_en;
    logic [NS:1]           r_vld;
    pstc_pkg::t_kind       r_kind [1:NS];
    logic signed [A_W-1:0] w_a;
    logic signed [33:0]    w_res [0:1];
    t_div                  r_div [0:QB];
    t_div                  n_div0;
    pstc_pkg::t_out_item   r_out;
    pstc_pkg::t_out_item   n_out;

    assign w_en    = !r_vld[NS] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NS];
    assign o_data  = r_out;
    assign w_a     = {i_cmd.angle, {SH{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind[1] <= i_cmd.kind;
            for (int k = 2; k <= NS; k++) begin
                r_kind[k] <= r_kind[k-1];
            end
        end
    end

    // sine lanes: lane 0 on the angle, lane 1 on the angle plus pi/2
    for (genvar g = 0; g < 2; g++) begin : g_lane
        localparam logic [63:0] KL = (g == 0) ? K_SIN : K_COS;

        logic [U_W-1:0]     r_u1;
        logic [U_W-1:0]     r_u2;
        logic [U_W-1:0]     r_u3;
        logic [Q_W-1:0]     r_est;
        logic [Q_W+30:0]    r_p;
        logic [31:0]        r_r;
        logic signed [33:0] r_x;
        logic [H_W+29:0]    w_prod;
        logic [Q_W+30:0]    w_diff;
        logic [31:0]        w_rr;
        logic signed [33:0] w_t1;
        logic signed [33:0] w_t2;
        logic signed [33:0] w_t3;
        logic signed [33:0] w_t4;
        logic signed [33:0] w_t5;
        logic signed [33:0] r_t1d1;
        logic signed [33:0] r_t1d2;
        logic signed [33:0] r_y;
        logic signed [33:0] r_yd1;
        logic signed [33:0] r_yd2;
        logic signed [33:0] r_yd3;
        logic signed [33:0] r_yd4;
        logic signed [33:0] r_yd5;
        logic signed [33:0] r_d;
        logic signed [33:0] r_s;

        assign w_prod = (H_W+30)'(r_u1[U_W-1:FR]) * (H_W+30)'(RC[29:0]);
        assign w_diff = (Q_W+31)'(r_u3) - r_p;
        assign w_rr   = (r_r >= TWO_PI_U[31:0]) ? (r_r - TWO_PI_U[31:0]) : r_r;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_u1   <= U_W'({w_a[A_W-1], w_a}) + KL[U_W-1:0];
                r_est  <= w_prod[32 +: Q_W];
                r_u2   <= r_u1;
                r_p    <= (Q_W+31)'(r_est) * (Q_W+31)'(TWO_PI_U[30:0]);
                r_u3   <= r_u2;
                r_r    <= w_diff[31:0];
                r_x    <= signed'({2'b00, w_rr}) - 34'(pstc_pkg::PI_Q);
                r_t1d1 <= w_t1;
                r_t1d2 <= r_t1d1;
                r_y    <= r_t1d2 + w_t3;
                r_yd1  <= r_y;
                r_yd2  <= r_yd1;
                r_d    <= w_t4 - r_yd2;
                r_yd3  <= r_yd2;
                r_yd4  <= r_yd3;
                r_yd5  <= r_yd4;
                r_s    <= w_t5 + r_yd5;
            end
        end

        pstc_mulq u_bx (.i_clk(i_clk), .i_en(w_en), .i_a(34'(pstc_pkg::B_Q)),
                        .i_b(r_x), .o_p(w_t1));
        pstc_mulq u_xx (.i_clk(i_clk), .i_en(w_en), .i_a(r_x),
                        .i_b(pstc_pkg::abs34(r_x)), .o_p(w_t2));
        pstc_mulq u_cx (.i_clk(i_clk), .i_en(w_en), .i_a(34'(pstc_pkg::C_Q)),
                        .i_b(w_t2), .o_p(w_t3));
        pstc_mulq u_yy (.i_clk(i_clk), .i_en(w_en), .i_a(r_y),
                        .i_b(pstc_pkg::abs34(r_y)), .o_p(w_t4));
        pstc_mulq u_pd (.i_clk(i_clk), .i_en(w_en), .i_a(34'(pstc_pkg::P_Q)),
                        .i_b(r_d), .o_p(w_t5));

        assign w_res[g] = r_s;
    end

    // divider setup: sin/cos rounding and tangent numerator/denominator
    always_comb begin
        logic signed [33:0] v;
        logic [33:0]        vm;
        logic [33:0]        vr;
        logic signed [33:0] sa;
        logic signed [33:0] ca;
        logic [31:0]        sm;
        logic [31:0]        cm;
        logic [49:0]        num;
        v            = r_kind[16].use_cos ? w_res[1] : w_res[0];
        vm           = pstc_pkg::abs34(v);
        vr           = (vm + (34'd1 << (RS - 1))) >> RS;
        sa           = pstc_pkg::abs34(w_res[0]);
        ca           = pstc_pkg::abs34(w_res[1]);
        sm           = sa[31:0];
        cm           = ca[31:0];
        num          = (50'(sm) << 17) + 50'(cm);
        n_div0       = '0;
        n_div0.sc    = v[33] ? -vr[31:0] : vr[31:0];
        n_div0.sneg  = w_res[0][33];
        n_div0.cneg  = w_res[1][33];
        n_div0.czero = (w_res[1] == '0);
        n_div0.d     = {cm, 1'b0};
        n_div0.ovf   = (33'(num[49:33]) >= n_div0.d);
        n_div0.rem   = 33'(num[49:33]);
        n_div0.nlo   = num[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div[0] <= n_div0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [33:0] w_sh;
        logic        w_ge;
        t_div        w_nx;

        assign w_sh = {r_div[k].rem, r_div[k].nlo[QB-1]};
        assign w_ge = (w_sh >= {1'b0, r_div[k].d});

        always_comb begin
            w_nx     = r_div[k];
            w_nx.rem = w_ge ? 33'(w_sh - {1'b0, r_div[k].d}) : w_sh[32:0];
            w_nx.nlo = {r_div[k].nlo[QB-2:0], 1'b0};
            w_nx.q   = {r_div[k].q[QB-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k+1] <= w_nx;
            end
        end
    end

    always_comb begin
        t_div            f;
        pstc_pkg::t_kind kd;
        logic            neg;
        f     = r_div[QB];
        kd    = r_kind[NS-1];
        neg   = f.sneg ^ f.cneg;
        n_out = '0;
        priority if (kd.is_nop) begin
            n_out = '0;
        end else if (!kd.is_tan) begin
            n_out.value = f.sc;
        end else if (f.czero) begin
            n_out.saturated = 1'b1;
            n_out.value     = f.sneg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else if (f.ovf || (!neg && f.q > 33'h07FFFFFFF) || (neg && f.q > 33'h080000000)) begin
            n_out.saturated = 1'b1;
            n_out.value     = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            n_out.value = neg ? -signed'(f.q[31:0]) : signed'(f.q[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while output stalled");

    a_sat_tan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && !r_kind[NS].is_tan) |-> !r_out.saturated)
        else $error("saturation flagged on a non-tangent result");

endmodule

`default_nettype wire

[rtl/parabolic_sine_cosine_tangent_unit.sv]
// ----------------------------------------------------------------------------
// parabolic_sine_cosine_tangent_unit: parabolic sin/cos/tan approximation
// Usage:
//   Input channel i_valid/o_ready carries i_data (selector and Q15.16 angle).
//   Output channel o_valid/i_ready carries o_data (Q15.16 value, saturation).
//   A transaction happens on a rising edge with valid and ready both high.
//   Selector 0 sine, 1 cosine, 2 tangent, 3 gives zero.
// Pipeline: intake register, queue head, 16 sine stages, divider setup,
//   33 divider stages and the output register lie between the input and
//   result transactions; every request takes the divider path to keep order.
// Throughput: one transaction per cycle while the receiver keeps i_ready high;
//   both sine lanes and each divider stage are fully pipelined.
// Stall: when a result waits with i_ready low the arithmetic pipeline freezes,
//   the queue fills, and then o_ready drops; nothing is dropped.
// Reset: synchronous, active low; clears all valid flags, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module parabolic_sine_cosine_tangent_unit #(
    parameter int ANGLE_FRAC_BITS = pstc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire pstc_pkg::t_in_item i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output pstc_pkg::t_out_item     o_data
);

    logic           w_push;
    logic           w_q_ready;
    pstc_pkg::t_cmd w_f_cmd;
    logic           w_q_valid;
    pstc_pkg::t_cmd w_q_cmd;
    logic           w_b_ready;

    pstc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .o_push   (w_push),
        .i_q_ready(w_q_ready),
        .o_cmd    (w_f_cmd)
    );

    pstc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_f_cmd),
        .o_ready(w_q_ready),
        .o_valid(w_q_valid),
        .o_data (w_q_cmd),
        .i_pop  (w_b_ready)
    );

    pstc_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_q_valid),
        .o_ready(w_b_ready),
        .i_cmd  (w_q_cmd),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

endmodule

`default_nettype wire

[tb/parabolic_sine_cosine_tangent_unit_test.sv]
// ----------------------------------------------------------------------------
// parabolic_sine_cosine_tangent_unit_test: sine/cosine/tangent unit check
// Drives directed and random angle/selector requests with random gaps on the
// input side and random stalls on the output side. A fixed-point predictor
// works out each expected result, and a scoreboard compares every result
// transaction field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parabolic_sine_cosine_tangent_unit_test;

    localparam int LATENCY = 53;
    localparam int RANDOM_ITEMS = 500;

    // Q4.28 multiply, round to nearest with ties away from zero
    function automatic longint mul_q28(input longint a, input longint b);
        longint unsigned ma, mb, m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = (ma * mb + (64'd1 << (pstc_pkg::WORK_FRAC - 1))) >> pstc_pkg::WORK_FRAC;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint parabolic_sine(input longint a);
        longint num, n, x, ax, y, ay;
        num = a + pstc_pkg::PI_Q;
        n = num / pstc_pkg::TWO_PI_Q;
        if (num % pstc_pkg::TWO_PI_Q < 0) n = n - 1;
        x = a - n * pstc_pkg::TWO_PI_Q;
        ax = x < 0 ? -x : x;
        y = mul_q28(pstc_pkg::B_Q, x) + mul_q28(pstc_pkg::C_Q, mul_q28(x, ax));
        ay = y < 0 ? -y : y;
        return mul_q28(pstc_pkg::P_Q, mul_q28(y, ay) - y) + y;
    endfunction

    function automatic longint to_q16(input longint v);
        longint unsigned m;
        m = ((v < 0 ? -v : v) + (64'd1 << 11))
            >> (pstc_pkg::WORK_FRAC - pstc_pkg::OUT_FRAC);
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic pstc_pkg::t_out_item predict_trig(input pstc_pkg::t_in_item req);
        pstc_pkg::t_out_item r;
        longint a, s, c;
        longint unsigned nm, dn, q;
        logic neg;
        r = '0;
        a = longint'(req.angle) <<< (pstc_pkg::WORK_FRAC - pstc_pkg::ANGLE_FRAC_BITS_DEF);
        case (req.req_type)
            pstc_pkg::REQ_SIN: r.value = 32'(to_q16(parabolic_sine(a)));
            pstc_pkg::REQ_COS: r.value = 32'(to_q16(parabolic_sine(a + pstc_pkg::HALF_PI_Q)));
            pstc_pkg::REQ_TAN: begin
                s = parabolic_sine(a);
                c = parabolic_sine(a + pstc_pkg::HALF_PI_Q);
                neg = (s < 0) != (c < 0);
                if (c == 0) begin
                    r.value = s >= 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
                    r.saturated = 1'b1;
                end else begin
                    nm = longint'(s < 0 ? -s : s) << pstc_pkg::OUT_FRAC;
                    dn = c < 0 ? -c : c;
                    q = (2 * nm + dn) / (2 * dn);
                    if (s == 0) neg = 1'b0;
                    if (!neg && q > 64'h7FFF_FFFF) begin
                        r.value = 32'h7FFF_FFFF;
                        r.saturated = 1'b1;
                    end else if (neg && q > 64'h8000_0000) begin
                        r.value = 32'h8000_0000;
                        r.saturated = 1'b1;
                    end else begin
                        r.value = 32'(neg ? -longint'(q) : longint'(q));
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    class trig_scoreboard;
        pstc_pkg::t_out_item pending_results[$];
        int errors;

        function void note_request(input pstc_pkg::t_in_item req);
            pending_results.push_back(predict_trig(req));
        endfunction

        function void check_result(input pstc_pkg::t_out_item got);
            pstc_pkg::t_out_item exp_r;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.value !== exp_r.value) begin
                $error("value: expected %h actual %h", exp_r.value, got.value);
                errors++;
            end
            if (got.saturated !== exp_r.saturated) begin
                $error("saturated: expected %b actual %b", exp_r.saturated,
                       got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    pstc_pkg::t_in_item  i_data = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    pstc_pkg::t_out_item o_data;

    trig_scoreboard sb = new();
    int stall_left = 0;

    parabolic_sine_cosine_tangent_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one request transaction; gap is spent before raising valid
    task automatic send_request(input logic [1:0] sel, input logic [31:0] ang,
                                input bit allow_gap);
        int g;
        pstc_pkg::t_in_item req;
        req.req_type = sel;
        req.angle = ang;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req);
    endtask

    function automatic logic [31:0] random_angle();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (p < 7) begin
            // near multiples of pi/2 to hit tangent poles and zeros
            return (($urandom_range(0, 40) - 20) * 32'd102944)
                   + $urandom_range(0, 8) - 4;
        end
        return $urandom();
    endfunction

    // output side: random stalls, result checked on each transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_data);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                stall_left = gap_len();
                i_ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        logic [31:0] corner_angles[8];
        corner_angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_921F,
                          32'hFFFE_6DE1, 32'h0003_243F, 32'h0000_0001,
                          32'hFFFF_FFFF};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (corner_angles[k]) begin
            send_request(pstc_pkg::REQ_SIN, corner_angles[k], 1'b0);
            send_request(pstc_pkg::REQ_COS, corner_angles[k], 1'b0);
            send_request(pstc_pkg::REQ_TAN, corner_angles[k], 1'b0);
        end
        send_request(pstc_pkg::REQ_NOP, 32'h1234_5678, 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_request(($urandom_range(0, 19) == 0) ? pstc_pkg::REQ_NOP
                         : 2'($urandom_range(0, 2)), random_angle(), n > 60);
        end
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
